/* sv/dfs_pkg.sv */
// shared types and constants of the frequency-switch sequencer
package dfs_pkg;
	localparam int RATE_W      = 33;
	localparam int LEVELS      = 8;
	localparam int LVL_W       = 3;
	localparam int DIV_W       = 7;
	localparam int SW_W        = 3;
	localparam int CNT_W       = 4;
	localparam int MAX_DIVIDER = 64;
	localparam int FLD_W       = 6;
	localparam logic [RATE_W-1:0] MHZ_IN_HZ = RATE_W'(1000000);

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_SET   = 2'd1,
		CMD_ROUND = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_TRANS_DIV  = 3'd0,
		KIND_SWITCH     = 3'd1,
		KIND_TARGET_DIV = 3'd2,
		KIND_ROUNDED    = 3'd3,
		KIND_ERROR      = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN_TAR, ST_SCAN_CUR, ST_CHECK, ST_DIV_INIT, ST_DIV_RUN,
		ST_DIV_NEXT, ST_EMIT0, ST_EMIT1, ST_EMIT2, ST_EMIT_ROUND, ST_EMIT_ERR
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic load;
		logic scan_start;
		logic scan_step;
		logic scan_tar;
		logic div_init;
		logic div_start;
		logic div_step;
		logic trial_next;
		logic commit;
		logic out_load;
		kind_t out_kind;
		logic  out_last;
	} dfs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic sw_error;
		logic no_search;
		logic div_done;
		logic trial_ok;
		logic trial_end;
	} dfs_sts_t;
endpackage

/* sv/dfs_ctrl.sv */
// controller state machine of the frequency-switch sequencer
module dfs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  dfs_pkg::cmd_t      in_cmd,
	output logic               out_valid,
	input  logic               out_stall,
	input  dfs_pkg::dfs_sts_t  sts,
	output dfs_pkg::dfs_cmd_t  cmd,
	output logic               idle
);
	dfs_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic can_load;

	assign out_valid = out_valid_q;
	assign can_load  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != dfs_pkg::ST_IDLE);
	assign idle      = (state_q == dfs_pkg::ST_IDLE) && !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dfs_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.out_kind = dfs_pkg::KIND_ERROR;
		unique case (state_q)
			dfs_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					unique case (in_cmd)
						dfs_pkg::CMD_LOAD: cmd.load = 1'b1;
						dfs_pkg::CMD_SET, dfs_pkg::CMD_ROUND: begin
							cmd.scan_start = 1'b1;
							state_d = dfs_pkg::ST_SCAN_TAR;
						end
						default: ;
					endcase
				end
			end
			dfs_pkg::ST_SCAN_TAR: begin
				cmd.scan_step = 1'b1;
				cmd.scan_tar  = 1'b1;
				if (sts.scan_done) begin
					if (in_cmd == dfs_pkg::CMD_ROUND)
						state_d = dfs_pkg::ST_EMIT_ROUND;
					else begin
						cmd.scan_start = 1'b1;
						state_d = dfs_pkg::ST_SCAN_CUR;
					end
				end
			end
			dfs_pkg::ST_SCAN_CUR: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) state_d = dfs_pkg::ST_CHECK;
			end
			dfs_pkg::ST_CHECK: begin
				if (sts.sw_error) state_d = dfs_pkg::ST_EMIT_ERR;
				else if (sts.no_search) state_d = dfs_pkg::ST_EMIT0;
				else begin
					cmd.div_init = 1'b1;
					state_d = dfs_pkg::ST_DIV_INIT;
				end
			end
			dfs_pkg::ST_DIV_INIT: begin
				if (sts.trial_end) state_d = dfs_pkg::ST_EMIT0;
				else begin
					cmd.div_start = 1'b1;
					state_d = dfs_pkg::ST_DIV_RUN;
				end
			end
			dfs_pkg::ST_DIV_RUN: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = dfs_pkg::ST_DIV_NEXT;
			end
			dfs_pkg::ST_DIV_NEXT: begin
				if (sts.trial_ok) state_d = dfs_pkg::ST_EMIT0;
				else begin
					cmd.trial_next = 1'b1;
					state_d = dfs_pkg::ST_DIV_INIT;
				end
			end
			dfs_pkg::ST_EMIT0: if (can_load) begin
				cmd.out_load = 1'b1;
				cmd.out_kind = dfs_pkg::KIND_TRANS_DIV;
				state_d = dfs_pkg::ST_EMIT1;
			end
			dfs_pkg::ST_EMIT1: if (can_load) begin
				cmd.out_load = 1'b1;
				cmd.out_kind = dfs_pkg::KIND_SWITCH;
				state_d = dfs_pkg::ST_EMIT2;
			end
			dfs_pkg::ST_EMIT2: if (can_load) begin
				cmd.out_load = 1'b1;
				cmd.out_kind = dfs_pkg::KIND_TARGET_DIV;
				cmd.out_last = 1'b1;
				cmd.commit   = 1'b1;
				state_d = dfs_pkg::ST_IDLE;
			end
			dfs_pkg::ST_EMIT_ROUND: if (can_load) begin
				cmd.out_load = 1'b1;
				cmd.out_kind = dfs_pkg::KIND_ROUNDED;
				cmd.out_last = 1'b1;
				state_d = dfs_pkg::ST_IDLE;
			end
			dfs_pkg::ST_EMIT_ERR: if (can_load) begin
				cmd.out_load = 1'b1;
				cmd.out_kind = dfs_pkg::KIND_ERROR;
				cmd.out_last = 1'b1;
				state_d = dfs_pkg::ST_IDLE;
			end
			default: state_d = dfs_pkg::ST_IDLE;
		endcase
	end

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result overwrites a stalled beat");
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != dfs_pkg::ST_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_commit_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (cmd.out_last && cmd.out_load))
		else $error("rate committed without final beat");
endmodule

/* sv/dfs_datapath.sv */
// profile table, level scan, trial divider and result register
module dfs_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dfs_pkg::dfs_cmd_t             cmd,
	output dfs_pkg::dfs_sts_t             sts,
	input  logic [dfs_pkg::CNT_W-1:0]     sw_count,
	input  logic [dfs_pkg::LVL_W-1:0]     level_index,
	input  logic [dfs_pkg::RATE_W-1:0]    entry_rate,
	input  logic [dfs_pkg::RATE_W-1:0]    entry_source_rate,
	input  logic [dfs_pkg::DIV_W-1:0]     entry_divider,
	input  logic [dfs_pkg::SW_W-1:0]      entry_switch,
	input  logic [dfs_pkg::RATE_W-1:0]    requested_rate,
	output logic [2:0]                    kind,
	output logic [dfs_pkg::RATE_W-1:0]    value,
	output logic                          last
);
	localparam int RW = dfs_pkg::RATE_W;
	localparam int DW = dfs_pkg::DIV_W;
	localparam int QC_W = 6;

	logic [RW-1:0] rate_tab_q [dfs_pkg::LEVELS];
	logic [RW-1:0] src_tab_q  [dfs_pkg::LEVELS];
	logic [DW-1:0] div_tab_q  [dfs_pkg::LEVELS];
	logic [dfs_pkg::SW_W-1:0] sw_tab_q [dfs_pkg::LEVELS];

	logic [RW-1:0] act_rate_q, req_q, scan_rate_q;
	logic [RW:0] top_q;
	logic [dfs_pkg::LVL_W-1:0] scan_idx_q, tar_q, cur_q;
	logic [DW-1:0] trial_q, hi_q;
	logic [QC_W-1:0] div_cnt_q;
	logic [RW-1:0] rem_q, quo_q, dvd_q;
	logic which_q, ok_first_q;
	logic [2:0] kind_q;
	logic [RW-1:0] value_q;
	logic last_q;

	logic [RW-1:0] r_at;
	logic hit;
	logic cnt_zero;
	logic [DW-1:0] dc, dt, lo, hi;
	logic [RW:0] rem_sh;
	logic [RW:0] rem_sub;
	logic [RW-1:0] quo_full;
	logic [dfs_pkg::FLD_W-1:0] wrap_best, wrap_tar;

	assign r_at = rate_tab_q[scan_idx_q];
	assign hit  = (r_at != '0) && (scan_rate_q >= r_at);
	assign dc   = div_tab_q[cur_q];
	assign dt   = div_tab_q[tar_q];
	assign lo   = (dc < dt) ? dc : dt;
	assign hi   = (dc < dt) ? dt : dc;

	assign cnt_zero      = (div_cnt_q == '0);
	assign sts.scan_done = hit || (scan_idx_q == '0);
	assign sts.sw_error  = ({1'b0, sw_tab_q[tar_q]} >= sw_count) ||
		({1'b0, sw_tab_q[cur_q]} >= sw_count);
	assign sts.no_search = (lo == '0);
	assign sts.trial_end = (trial_q >= hi_q);
	assign sts.div_done  = cnt_zero && which_q;
	// quotient of one source rate, then the other
	assign quo_full      = {quo_q[RW-2:0], ~rem_sub[RW]};
	assign sts.trial_ok  = ok_first_q && ({1'b0, quo_q} <= top_q);

	assign rem_sh  = {rem_q, dvd_q[RW-1]};
	assign rem_sub = rem_sh - {{(RW+1-DW){1'b0}}, trial_q};

	assign wrap_best = dfs_pkg::FLD_W'(trial_q - DW'(1));
	assign wrap_tar  = dfs_pkg::FLD_W'(dt - DW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_rate_q <= '0;
			for (int i = 0; i < dfs_pkg::LEVELS; i++) begin
				rate_tab_q[i] <= '0;
				src_tab_q[i]  <= '0;
				div_tab_q[i]  <= '0;
				sw_tab_q[i]   <= '0;
			end
		end else if (cmd.commit) begin
			act_rate_q <= req_q;
		end else if (cmd.load) begin
			rate_tab_q[level_index] <= entry_rate;
			src_tab_q[level_index]  <= entry_source_rate;
			div_tab_q[level_index]  <= entry_divider;
			sw_tab_q[level_index]   <= entry_switch;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) req_q <= requested_rate;
		if (cmd.scan_step && sts.scan_done) begin
			if (cmd.scan_tar) tar_q <= hit ? scan_idx_q : '0;
			else cur_q <= hit ? scan_idx_q : '0;
		end
		if (cmd.scan_start) begin
			scan_idx_q  <= dfs_pkg::LVL_W'(dfs_pkg::LEVELS - 1);
			scan_rate_q <= cmd.capture ? requested_rate : act_rate_q;
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q - 1'b1;
		end
		if (cmd.scan_step && sts.scan_done && cmd.scan_tar) begin
			top_q <= {1'b0, ((act_rate_q > req_q) ? act_rate_q : req_q)} +
				{1'b0, dfs_pkg::MHZ_IN_HZ};
		end
		if (cmd.scan_step && sts.scan_done && !cmd.scan_tar) begin
			trial_q <= '0;
			hi_q    <= '0;
		end
		if (cmd.div_init) begin
			trial_q <= lo;
			hi_q    <= (hi == '0) ? DW'(dfs_pkg::MAX_DIVIDER) : hi;
		end else if (cmd.trial_next) begin
			trial_q <= trial_q + 1'b1;
		end
		if (cmd.div_start) begin
			which_q   <= 1'b0;
			dvd_q     <= src_tab_q[cur_q];
			rem_q     <= '0;
			quo_q     <= '0;
			div_cnt_q <= QC_W'(RW - 1);
			ok_first_q <= 1'b1;
		end else if (cmd.div_step) begin
			rem_q <= rem_sub[RW] ? rem_sh[RW-1:0] : rem_sub[RW-1:0];
			dvd_q <= {dvd_q[RW-2:0], 1'b0};
			quo_q <= quo_full;
			if (cnt_zero && !which_q) begin
				which_q    <= 1'b1;
				ok_first_q <= ({1'b0, quo_full} <= top_q);
				dvd_q      <= src_tab_q[tar_q];
				rem_q      <= '0;
				quo_q      <= '0;
				div_cnt_q  <= QC_W'(RW - 1);
			end else begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			kind_q <= cmd.out_kind;
			last_q <= cmd.out_last;
			unique case (cmd.out_kind)
				dfs_pkg::KIND_TRANS_DIV: begin
					value_q <= (hi_q == '0) ?
						RW'(dfs_pkg::FLD_W'(((hi == '0) ? DW'(dfs_pkg::MAX_DIVIDER) : hi)
							- DW'(1))) :
						RW'(wrap_best);
				end
				dfs_pkg::KIND_SWITCH:     value_q <= RW'(sw_tab_q[tar_q]);
				dfs_pkg::KIND_TARGET_DIV: value_q <= RW'(wrap_tar);
				dfs_pkg::KIND_ROUNDED:    value_q <= rate_tab_q[tar_q];
				default:                  value_q <= '0;
			endcase
		end
	end

	assign kind  = kind_q;
	assign value = value_q;
	assign last  = last_q;
endmodule

/* sv/dfs_switch_sequencer.sv */
// top level of the frequency-switch sequencer
//  channel  | signals                         | direction
//  request  | in_valid, in_stall, fields      | in
//  result   | out_valid, out_stall, fields    | out
//  config   | cfg_valid, cfg_ready, cfg_data  | in
// load: written in the idle state; round: one level scan, then the result beat
// set: two level scans, then per trial divider two 33-bit restoring divisions (current and
// target source rate) in one shared divider, up to 126 trials
// reset clears the profile table, current rate and sets the switch count to 8
// input stalled while a request is in progress; a stalled result holds the emit state
module dfs_switch_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [2:0]  level_index,
	input  logic [32:0] entry_rate,
	input  logic [32:0] entry_source_rate,
	input  logic [6:0]  entry_divider,
	input  logic [2:0]  entry_switch,
	input  logic [32:0] requested_rate,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [32:0] value,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);
	dfs_pkg::dfs_cmd_t cmd;
	dfs_pkg::dfs_sts_t sts;
	logic idle;
	logic [3:0] sw_count_q;
	dfs_pkg::cmd_t cmd_q;
	dfs_pkg::cmd_t cmd_sel;

	assign cfg_ready = 1'b1;
	assign cmd_sel = (in_stall) ? cmd_q : dfs_pkg::cmd_t'(command);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_count_q <= 4'd8;
			cmd_q      <= dfs_pkg::CMD_NONE;
		end else begin
			if (cfg_valid) sw_count_q <= cfg_data;
			if (cmd.capture) cmd_q <= dfs_pkg::cmd_t'(command);
		end
	end

	dfs_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .in_cmd(cmd_sel),
		.out_valid, .out_stall, .sts, .cmd, .idle
	);

	dfs_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .sw_count(sw_count_q), .level_index,
		.entry_rate, .entry_source_rate, .entry_divider, .entry_switch,
		.requested_rate, .kind, .value, .last
	);

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> idle)
		else $error("configuration beat while busy");
	a_last_set: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == dfs_pkg::KIND_TARGET_DIV) |-> last)
		else $error("target divider beat not last");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == dfs_pkg::KIND_ERROR) |-> (value == '0))
		else $error("error beat carries a value");
endmodule

/* tb/tb_top.sv */
// self-checking testbench of the frequency-switch sequencer
`timescale 1ns / 100ps

class dfs_scoreboard;
	logic [32:0] rate_tab [8];
	logic [32:0] src_tab [8];
	logic [6:0]  div_tab [8];
	logic [2:0]  sw_tab [8];
	logic [32:0] now_rate;
	logic [3:0]  sw_count;
	logic [2:0]  exp_kind [$];
	logic [32:0] exp_value [$];
	logic        exp_last [$];
	int          mismatches;

	function new();
		for (int i = 0; i < 8; i++) begin
			rate_tab[i] = '0;
			src_tab[i] = '0;
			div_tab[i] = '0;
			sw_tab[i] = '0;
		end
		now_rate = '0;
		sw_count = 4'd8;
		mismatches = 0;
	endfunction

	function int level_of(logic [32:0] r);
		for (int i = 7; i >= 0; i--)
			if (rate_tab[i] != 0 && r >= rate_tab[i])
				return i;
		return 0;
	endfunction

	function void push(dfs_pkg::kind_t k, logic [32:0] v, logic l);
		exp_kind.push_back(k);
		exp_value.push_back(v);
		exp_last.push_back(l);
	endfunction

	function logic [32:0] wrap(int d);
		return 33'((d + 63) % 64);
	endfunction

	function void note_request(logic [1:0] cmd, logic [2:0] idx, logic [32:0] er,
			logic [32:0] es, logic [6:0] ed, logic [2:0] esw, logic [32:0] req);
		int cur, tar, lo, hi, best;
		logic [33:0] top;
		case (cmd)
			dfs_pkg::CMD_LOAD: begin
				rate_tab[idx] = er;
				src_tab[idx] = es;
				div_tab[idx] = ed;
				sw_tab[idx] = esw;
			end
			dfs_pkg::CMD_ROUND: push(dfs_pkg::KIND_ROUNDED, rate_tab[level_of(req)], 1'b1);
			dfs_pkg::CMD_SET: begin
				cur = level_of(now_rate);
				tar = level_of(req);
				if (sw_tab[tar] >= sw_count || sw_tab[cur] >= sw_count) begin
					push(dfs_pkg::KIND_ERROR, '0, 1'b1);
				end else begin
					lo = div_tab[cur] < div_tab[tar] ? div_tab[cur] : div_tab[tar];
					hi = div_tab[cur] < div_tab[tar] ? div_tab[tar] : div_tab[cur];
					top = 34'(now_rate > req ? now_rate : req) + 34'(dfs_pkg::MHZ_IN_HZ);
					if (hi == 0) hi = 64;
					best = hi;
					if (lo != 0)
						for (int d = lo; d < hi; d++)
							if ({1'b0, src_tab[cur] / d} <= top
									&& {1'b0, src_tab[tar] / d} <= top) begin
								best = d;
								break;
							end
					push(dfs_pkg::KIND_TRANS_DIV, wrap(best), 1'b0);
					push(dfs_pkg::KIND_SWITCH, 33'(sw_tab[tar]), 1'b0);
					push(dfs_pkg::KIND_TARGET_DIV, wrap(div_tab[tar]), 1'b1);
					now_rate = req;
				end
			end
			default: ;
		endcase
	endfunction

	function void check_result(logic [2:0] k, logic [32:0] v, logic l);
		logic [2:0] ek;
		logic [32:0] ev;
		logic el;
		if (exp_kind.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result kind %0d value %0d last %0d", k, v, l);
			return;
		end
		ek = exp_kind.pop_front();
		ev = exp_value.pop_front();
		el = exp_last.pop_front();
		if (k !== ek || v !== ev || l !== el) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp kind %0d value %0d last %0d, got %0d %0d %0d",
					ek, ev, el, k, v, l);
		end
	endfunction
endclass

module tb_top;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  command = '0;
	logic [2:0]  level_index = '0;
	logic [32:0] entry_rate = '0;
	logic [32:0] entry_source_rate = '0;
	logic [6:0]  entry_divider = '0;
	logic [2:0]  entry_switch = '0;
	logic [32:0] requested_rate = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [2:0]  kind;
	logic [32:0] value;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data = '0;

	dfs_scoreboard board = new();
	bit calm = 1'b0;
	bit hold_start = 1'b0;
	bit hold_on = 1'b0;

	dfs_switch_sequencer dut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(kind, value, last);
		if (hold_on)
			out_stall <= 1'b1;
		else
			out_stall <= calm ? 1'b0 : ($urandom_range(99) < 35);
	end

	// long receiver hold-off, counted here
	initial begin
		wait (hold_start);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (300) @(posedge clk);
		hold_on <= 1'b0;
	end

	task automatic send(logic [1:0] cmd, logic [2:0] idx, logic [32:0] er,
			logic [32:0] es, logic [6:0] ed, logic [2:0] esw, logic [32:0] req);
		while (!calm && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		level_index <= idx;
		entry_rate <= er;
		entry_source_rate <= es;
		entry_divider <= ed;
		entry_switch <= esw;
		requested_rate <= req;
		do @(posedge clk); while (in_stall);
		board.note_request(cmd, idx, er, es, ed, esw, req);
	endtask

	task automatic load(logic [2:0] idx, logic [32:0] er, logic [32:0] es,
			logic [6:0] ed, logic [2:0] esw);
		send(dfs_pkg::CMD_LOAD, idx, er, es, ed, esw, 33'($urandom));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.exp_kind.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_count(logic [3:0] n);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= n;
		do @(posedge clk); while (!cfg_ready);
		board.sw_count = n;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [32:0] rnd33();
		return {1'($urandom), $urandom};
	endfunction

	function automatic logic [32:0] rate_pick();
		case ($urandom_range(3))
			0: return rnd33();
			1: return 33'($urandom_range(100, 3000)) * 33'd1000000;
			2: return board.rate_tab[$urandom_range(7)] + 33'($urandom_range(2)) - 33'd1;
			default: return 33'($urandom_range(4000)) * 33'd1000000;
		endcase
	endfunction

	task automatic random_load();
		logic [32:0] r;
		r = ($urandom_range(9) == 0) ? 33'd0 : 33'($urandom_range(50, 2500)) * 33'd1000000;
		if ($urandom_range(9) == 0) r = rnd33();
		load(3'($urandom_range(7)), r,
			($urandom_range(4) == 0) ? rnd33() : 33'($urandom_range(100, 6000)) * 33'd1000000,
			($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(64)),
			3'($urandom_range(7)));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		calm = 1'b1;
		// empty table and unused command
		send(dfs_pkg::CMD_ROUND, '0, '0, '0, '0, '0, 33'h1FFFFFFFF);
		send(dfs_pkg::CMD_SET, '0, '0, '0, '0, '0, 33'd0);
		send(dfs_pkg::CMD_NONE, 3'd7, '1, '1, '1, 3'd7, '1);
		load(3'd0, 33'd100000000, 33'd800000000, 7'd4, 3'd0);
		load(3'd3, 33'd400000000, 33'd1600000000, 7'd2, 3'd1);
		load(3'd7, 33'h1FFFFFFFF, 33'h1FFFFFFFF, 7'd64, 3'd7);
		load(3'd5, 33'd0, 33'd0, 7'd0, 3'd7);
		send(dfs_pkg::CMD_ROUND, '0, '0, '0, '0, '0, 33'd99999999);
		send(dfs_pkg::CMD_ROUND, '0, '0, '0, '0, '0, 33'd400000000);
		send(dfs_pkg::CMD_ROUND, '0, '0, '0, '0, '0, 33'h1FFFFFFFF);
		send(dfs_pkg::CMD_SET, '0, '0, '0, '0, '0, 33'd400000000);
		send(dfs_pkg::CMD_SET, '0, '0, '0, '0, '0, 33'd100000000);
		send(dfs_pkg::CMD_SET, '0, '0, '0, '0, '0, 33'h1FFFFFFFF);
		load(3'd6, 33'd500000000, 33'd0, 7'd0, 3'd2);
		send(dfs_pkg::CMD_SET, '0, '0, '0, '0, '0, 33'd500000000);
		send(dfs_pkg::CMD_SET, '0, '0, '0, '0, '0, 33'd100000000);
		load(3'd2, 33'd200000000, 33'd6000000000, 7'd127, 3'd3);
		send(dfs_pkg::CMD_SET, '0, '0, '0, '0, '0, 33'd250000000);
		write_count(4'd2);
		send(dfs_pkg::CMD_SET, '0, '0, '0, '0, '0, 33'd400000000);
		write_count(4'd0);
		send(dfs_pkg::CMD_SET, '0, '0, '0, '0, '0, 33'd100000000);
		write_count(4'd15);
		send(dfs_pkg::CMD_SET, '0, '0, '0, '0, '0, 33'd100000000);
		calm = 1'b0;
		// long receiver hold-off while requests pile up
		hold_start = 1'b1;
		for (int i = 0; i < 8; i++)
			send(dfs_pkg::CMD_ROUND, '0, '0, '0, '0, '0, rate_pick());
		for (int i = 0; i < 200; i++) begin
			if (i == 60) write_count(4'd8);
			if (i == 120) write_count(4'($urandom_range(3, 15)));
			if (i == 170) write_count(4'd8);
			calm = (i >= 80 && i < 110);
			if ($urandom_range(99) < 30) random_load();
			else if ($urandom_range(99) < 5) send(dfs_pkg::CMD_NONE, 3'($urandom),
					rnd33(), rnd33(), 7'($urandom), 3'($urandom), rnd33());
			else send($urandom_range(1) ? dfs_pkg::CMD_SET : dfs_pkg::CMD_ROUND,
					3'($urandom), rnd33(), rnd33(), 7'($urandom), 3'($urandom),
					rate_pick());
		end
		drain();
		if (board.mismatches == 0 && board.exp_kind.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#400ms;
		$display("Verification failed");
		$finish;
	end
endmodule

/* sim.f */
sv/dfs_pkg.sv
sv/dfs_ctrl.sv
sv/dfs_datapath.sv
sv/dfs_switch_sequencer.sv
tb/tb_top.sv
